>>> rtl/tdpca_pkg.sv
// ----------------------------------------------------------------------------
// tdpca_pkg
// Shared types, sizes and codes of the 2dpca row projection block.
// ----------------------------------------------------------------------------
package tdpca_pkg;

  localparam int MAX_COLS       = 64;
  localparam int MAX_ROWS       = 64;
  localparam int MAX_COMPONENTS = 32;

  localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CMP_W   = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int CCNT_W  = $clog2(MAX_COLS + 1);
  localparam int RCNT_W  = $clog2(MAX_ROWS + 1);
  localparam int MADDR_W = $clog2(MAX_ROWS * MAX_COLS);

  localparam int SAMPLE_W = 16;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int PROD_W   = DIFF_W + SAMPLE_W;
  localparam int ACC_W    = 48;
  localparam int FRAC_W   = 15;
  localparam int SHR_W    = ACC_W - FRAC_W;
  localparam int COEF_W   = 40;

  localparam int NCAP     = (MAX_COMPONENTS < 32) ? MAX_COMPONENTS : 32;
  localparam int COLS_RST = (MAX_COLS < 64) ? MAX_COLS : 64;
  localparam int ROWS_RST = (MAX_ROWS < 64) ? MAX_ROWS : 64;

  localparam logic [1:0] ACT_BASIS = 2'd0;
  localparam logic [1:0] ACT_MEAN  = 2'd1;
  localparam logic [1:0] ACT_PIXEL = 2'd2;

  localparam logic [1:0] CFG_N_COMPONENTS = 2'd0;
  localparam logic [1:0] CFG_COLS_IN_USE  = 2'd1;
  localparam logic [1:0] CFG_ROWS_IN_USE  = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [5:0]         first_index;
    logic [5:0]         second_index;
    logic signed [15:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         row_number;
    logic [4:0]         component_number;
    logic signed [39:0] coefficient;
    logic               last_of_row;
  } out_item_t;

  typedef struct packed {
    logic                     valid;
    logic                     wr;
    logic                     pix;
    logic                     last;
    logic [COL_W-1:0]         col;
    logic [CMP_W-1:0]         dest;
    logic signed [DIFF_W-1:0] data;
  } tok_t;

  typedef struct packed {
    logic             row_end;
    logic [ROW_W-1:0] row;
  } front_stat_t;

endpackage

>>> rtl/tdpca_cell.sv
// ----------------------------------------------------------------------------
// tdpca_cell
// One component cell: basis column memory, multiply-accumulate and a
// result hold register that shifts toward the head of the chain.
// ----------------------------------------------------------------------------
module tdpca_cell
  import tdpca_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  tok_t                    tok_in,
  output tok_t                    tok_out,
  input  logic                    shift,
  input  logic signed [ACC_W-1:0] hold_in,
  output logic signed [ACC_W-1:0] hold_out,
  output logic                    cap
);

  logic signed [SAMPLE_W-1:0] mem [MAX_COLS];
  logic signed [SAMPLE_W-1:0] basis_q_r;
  tok_t                       tok_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic                       pv_r;
  logic                       pl_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [ACC_W-1:0]    hold_r;
  logic                       cap_r;
  logic signed [PROD_W-1:0]   op_a;
  logic signed [PROD_W-1:0]   op_b;
  logic signed [ACC_W-1:0]    sum;

  assign op_a = {{(PROD_W-DIFF_W){tok_r.data[DIFF_W-1]}}, tok_r.data};
  assign op_b = {{(PROD_W-SAMPLE_W){basis_q_r[SAMPLE_W-1]}}, basis_q_r};
  assign sum  = acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  // basis column store
  always_ff @(posedge clk) begin
    if (tok_in.valid && tok_in.wr && tok_in.dest == '0) begin
      mem[tok_in.col] <= tok_in.data[SAMPLE_W-1:0];
    end
    if (tok_in.valid && tok_in.pix) begin
      basis_q_r <= mem[tok_in.col];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (shift) begin
      hold_r <= hold_in;
    end else if (pv_r && pl_r) begin
      hold_r <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in.valid) begin
      tok_r.wr   <= tok_in.wr;
      tok_r.pix  <= tok_in.pix;
      tok_r.last <= tok_in.last;
      tok_r.col  <= tok_in.col;
      tok_r.dest <= tok_in.dest - CMP_W'(1);
      tok_r.data <= tok_in.data;
    end
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
      pv_r        <= 1'b0;
      pl_r        <= 1'b0;
      acc_r       <= '0;
      cap_r       <= 1'b0;
    end else begin
      tok_r.valid <= tok_in.valid;
      pv_r        <= tok_r.valid && tok_r.pix;
      pl_r        <= tok_r.last;
      cap_r       <= pv_r && pl_r;
      if (pv_r) begin
        acc_r <= pl_r ? '0 : sum;
      end
    end
  end

  assign tok_out  = tok_r;
  assign hold_out = hold_r;
  assign cap      = cap_r;

endmodule

>>> rtl/tdpca_front.sv
// ----------------------------------------------------------------------------
// tdpca_front
// Mean store, raster position counters and the token that enters the chain.
// ----------------------------------------------------------------------------
module tdpca_front
  import tdpca_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  in_item_t          item,
  input  logic [CCNT_W-1:0] cols_in_use,
  input  logic [RCNT_W-1:0] rows_in_use,
  output tok_t              tok,
  output front_stat_t       stat
);

  logic signed [SAMPLE_W-1:0] mem [MAX_ROWS * MAX_COLS];
  logic signed [SAMPLE_W-1:0] mean_q_r;
  logic [COL_W-1:0]           col_r;
  logic [ROW_W-1:0]           row_r;
  tok_t                       f_r;
  logic                       pix_acc;
  logic                       mean_wr;
  logic                       basis_wr;
  logic                       row_end;
  logic [MADDR_W-1:0]         waddr;
  logic [MADDR_W-1:0]         raddr;
  logic signed [DIFF_W-1:0]   pix_ext;
  logic signed [DIFF_W-1:0]   mean_ext;

  assign pix_acc  = accept && item.action == ACT_PIXEL;
  assign mean_wr  = accept && item.action == ACT_MEAN &&
                    int'(item.first_index) < MAX_ROWS &&
                    int'(item.second_index) < MAX_COLS;
  assign basis_wr = accept && item.action == ACT_BASIS &&
                    int'(item.first_index) < MAX_COLS &&
                    int'(item.second_index) < MAX_COMPONENTS;
  assign row_end  = int'(col_r) + 1 >= int'(cols_in_use);
  assign waddr    = MADDR_W'(int'(item.first_index) * MAX_COLS + int'(item.second_index));
  assign raddr    = MADDR_W'(int'(row_r) * MAX_COLS + int'(col_r));

  always_ff @(posedge clk) begin
    if (mean_wr) begin
      mem[waddr] <= item.sample_value;
    end
    if (pix_acc) begin
      mean_q_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc || basis_wr) begin
      f_r.wr   <= basis_wr;
      f_r.pix  <= pix_acc;
      f_r.last <= pix_acc && row_end;
      f_r.col  <= pix_acc ? col_r : COL_W'(item.first_index);
      f_r.dest <= CMP_W'(item.second_index);
      f_r.data <= {item.sample_value[SAMPLE_W-1], item.sample_value};
    end
    if (!rst_n) begin
      f_r.valid <= 1'b0;
      col_r     <= '0;
      row_r     <= '0;
    end else begin
      f_r.valid <= pix_acc || basis_wr;
      if (pix_acc) begin
        if (row_end) begin
          col_r <= '0;
          row_r <= (int'(row_r) + 1 < int'(rows_in_use)) ? row_r + ROW_W'(1) : '0;
        end else begin
          col_r <= col_r + COL_W'(1);
        end
      end
    end
  end

  assign pix_ext  = f_r.data;
  assign mean_ext = {mean_q_r[SAMPLE_W-1], mean_q_r};

  always_comb begin
    tok = f_r;
    if (f_r.pix) begin
      tok.data = pix_ext - mean_ext;
    end
  end

  assign stat.row_end = pix_acc && row_end;
  assign stat.row     = row_r;

endmodule

>>> rtl/two_d_pca_row_projection.sv
// ----------------------------------------------------------------------------
// two_d_pca_row_projection
// 2dpca projection of raster-order image rows onto leading basis vectors.
// ----------------------------------------------------------------------------
// Input channel (in_*): one transfer loads a basis entry, loads a mean entry
// or feeds the next pixel in raster order. Basis and mean loads must come
// before the pixels that use them. Configuration (cfg_*) is always ready; the
// user must write it only while the block is idle, which the block does not
// enforce. Each pixel enters a chain of MAX_COMPONENTS cells, one cell per
// component, moving one cell per cycle; every cell multiplies the mean-removed
// pixel by its basis entry and accumulates. Loads and non-final pixels are
// taken one per cycle. The last pixel of a row closes the input until that
// row's coefficients are out: they appear one per cycle while the receiver
// takes them, in component order, the last flagged. The input reopens in the
// cycle after the last coefficient is loaded into the output register; a
// stalled receiver only holds that register and the shift of results out of
// the chain.
// Reset clears the row and column counters, the accumulators and out_valid,
// and sets n_components 1, cols_in_use 64, rows_in_use 64. Basis and mean
// stores are not cleared and hold garbage until loaded.
// ----------------------------------------------------------------------------
module two_d_pca_row_projection
  import tdpca_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);

  logic [5:0]              ncomp_r;
  logic [CCNT_W-1:0]       cols_r;
  logic [RCNT_W-1:0]       rows_r;
  logic                    pend_r;
  logic                    full_r;
  logic [5:0]              k_r;
  logic [ROW_W-1:0]        row_q_r;
  logic                    out_valid_r;
  out_item_t               out_r;

  tok_t                    tok_w  [MAX_COMPONENTS+1];
  logic signed [ACC_W-1:0] hold_w [MAX_COMPONENTS+1];
  logic                    cap_w  [MAX_COMPONENTS];
  front_stat_t             stat;
  logic                    in_acc;
  logic                    cfg_acc;
  logic                    emit;
  logic                    last_k;
  logic signed [SHR_W-1:0] shr;
  logic [5:0]              cfg_v6;

  assign in_ready  = !pend_r;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign emit      = full_r && (!out_valid_r || out_ready);
  assign last_k    = 6'(k_r + 6'd1) == ncomp_r;
  assign shr       = hold_w[0][ACC_W-1:FRAC_W];
  assign cfg_v6    = cfg_data[5:0];

  tdpca_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_acc),
    .item        (in_data),
    .cols_in_use (cols_r),
    .rows_in_use (rows_r),
    .tok         (tok_w[0]),
    .stat        (stat)
  );

  assign hold_w[MAX_COMPONENTS] = '0;

  for (genvar g = 0; g < MAX_COMPONENTS; g++) begin : g_cell
    tdpca_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .tok_in   (tok_w[g]),
      .tok_out  (tok_w[g+1]),
      .shift    (emit),
      .hold_in  (hold_w[g+1]),
      .hold_out (hold_w[g]),
      .cap      (cap_w[g])
    );
  end

  always_ff @(posedge clk) begin
    if (stat.row_end) begin
      row_q_r <= stat.row;
    end
    if (emit) begin
      out_r.row_number       <= 6'(row_q_r);
      out_r.component_number <= k_r[4:0];
      out_r.coefficient      <= {{(COEF_W-SHR_W){shr[SHR_W-1]}}, shr};
      out_r.last_of_row      <= last_k;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncomp_r     <= 6'd1;
      cols_r      <= CCNT_W'(COLS_RST);
      rows_r      <= RCNT_W'(ROWS_RST);
      pend_r      <= 1'b0;
      full_r      <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_acc) begin
        unique case (cfg_index)
          CFG_N_COMPONENTS: begin
            if (cfg_v6 == 6'd0) begin
              ncomp_r <= 6'd1;
            end else if (int'(cfg_v6) > NCAP) begin
              ncomp_r <= 6'(NCAP);
            end else begin
              ncomp_r <= cfg_v6;
            end
          end
          CFG_COLS_IN_USE: begin
            if (cfg_data == 7'd0) begin
              cols_r <= CCNT_W'(1);
            end else if (int'(cfg_data) > MAX_COLS) begin
              cols_r <= CCNT_W'(MAX_COLS);
            end else begin
              cols_r <= CCNT_W'(cfg_data);
            end
          end
          CFG_ROWS_IN_USE: begin
            if (cfg_data == 7'd0) begin
              rows_r <= RCNT_W'(1);
            end else if (int'(cfg_data) > MAX_ROWS) begin
              rows_r <= RCNT_W'(MAX_ROWS);
            end else begin
              rows_r <= RCNT_W'(cfg_data);
            end
          end
          default: begin
          end
        endcase
      end

      if (cap_w[MAX_COMPONENTS-1]) begin
        full_r <= 1'b1;
      end

      if (emit) begin
        out_valid_r <= 1'b1;
        if (last_k) begin
          k_r    <= '0;
          full_r <= 1'b0;
          pend_r <= 1'b0;
        end else begin
          k_r <= k_r + 6'd1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (stat.row_end) begin
        pend_r <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> rtl/tdpca_checker.sv
// ----------------------------------------------------------------------------
// tdpca_checker
// Port-level checks of the row projection block, bound to the top level.
// ----------------------------------------------------------------------------
module tdpca_checker
  import tdpca_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data,
  input logic      cfg_valid,
  input logic      cfg_ready,
  input logic [1:0] cfg_index,
  input logic [6:0] cfg_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // results of a row leave back to back once the receiver takes them
  a_comp_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_of_row |=>
      out_valid && out_data.component_number ==
        5'($past(out_data.component_number) + 5'd1))
    else $error("component sequence broken");

  // input stays closed while a row is still being delivered
  a_in_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_of_row |-> !in_ready)
    else $error("input open during row output");

  // no result right after the last of a row
  a_row_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last_of_row |=> !out_valid)
    else $error("result follows end of row");

endmodule

bind two_d_pca_row_projection tdpca_checker u_checker (.*);

>>> tb/two_d_pca_row_projection_checker.sv
// ----------------------------------------------------------------------------
// two_d_pca_row_projection_checker
// Watches the input, output and register channels of the 2dpca row projection
// block. It keeps its own copy of the basis and mean stores, the accumulators
// and the row and column position. From every input transfer it computes the
// coefficients that the block must emit, and checks each output transfer
// against the oldest one still waiting.
// ----------------------------------------------------------------------------
module two_d_pca_row_projection_checker
  import tdpca_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  in_item_t   in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  out_item_t  out_data,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data,
  output int         fail_count,
  output int         coef_pending,
  output int         coef_checked
);

  localparam longint COEF_HI    = 64'sd549755813887;
  localparam longint COEF_LO    = -64'sd549755813888;

  logic signed [15:0] basis_mem [MAX_COLS*MAX_COMPONENTS];
  logic signed [15:0] mean_mem  [MAX_ROWS*MAX_COLS];
  longint             acc       [MAX_COMPONENTS];
  int                 row_pos;
  int                 col_pos;
  int                 n_used;
  int                 cols_used;
  int                 rows_used;
  out_item_t          coef_expected_q [$];

  function automatic int clamp_cfg(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic clear_projection();
    for (int k = 0; k < MAX_COMPONENTS; k++) acc[k] = 0;
    row_pos   = 0;
    col_pos   = 0;
    n_used    = 1;
    cols_used = COLS_RST;
    rows_used = ROWS_RST;
    coef_expected_q.delete();
  endtask

  task automatic write_register(logic [1:0] idx, logic [6:0] val);
    case (idx)
      CFG_N_COMPONENTS: n_used    = clamp_cfg(int'(val[5:0]), NCAP);
      CFG_COLS_IN_USE:  cols_used = clamp_cfg(int'(val), MAX_COLS);
      CFG_ROWS_IN_USE:  rows_used = clamp_cfg(int'(val), MAX_ROWS);
      default: ;
    endcase
  endtask

  task automatic project_input(in_item_t it);
    longint    diff;
    longint    coef;
    out_item_t e;
    case (it.action)
      ACT_BASIS: begin
        if (int'(it.second_index) < MAX_COMPONENTS && int'(it.first_index) < MAX_COLS)
          basis_mem[int'(it.first_index)*MAX_COMPONENTS + int'(it.second_index)] =
            it.sample_value;
      end
      ACT_MEAN: begin
        if (int'(it.first_index) < MAX_ROWS && int'(it.second_index) < MAX_COLS)
          mean_mem[int'(it.first_index)*MAX_COLS + int'(it.second_index)] = it.sample_value;
      end
      ACT_PIXEL: begin
        diff = longint'($signed(it.sample_value)) -
               longint'($signed(mean_mem[row_pos*MAX_COLS + col_pos]));
        for (int k = 0; k < MAX_COMPONENTS; k++)
          acc[k] += diff * longint'($signed(basis_mem[col_pos*MAX_COMPONENTS + k]));
        if (col_pos + 1 < cols_used) begin
          col_pos++;
        end else begin
          for (int k = 0; k < n_used; k++) begin
            coef = acc[k] >>> FRAC_W;
            if (coef > COEF_HI) coef = COEF_HI;
            if (coef < COEF_LO) coef = COEF_LO;
            e.row_number       = 6'(row_pos);
            e.component_number = 5'(k);
            e.coefficient      = 40'(coef);
            e.last_of_row      = (k == n_used - 1);
            coef_expected_q.push_back(e);
          end
          for (int k = 0; k < MAX_COMPONENTS; k++) acc[k] = 0;
          col_pos = 0;
          row_pos = (row_pos + 1 < rows_used) ? row_pos + 1 : 0;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch_channels
    out_item_t want;
    if (!rst_n) begin
      clear_projection();
    end else begin
      if (out_valid && out_ready) begin
        if (coef_expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: expected none, got row/comp/coef/last %0d/%0d/%0d/%0b", $time,
                   out_data.row_number, out_data.component_number,
                   out_data.coefficient, out_data.last_of_row);
        end else begin
          want = coef_expected_q.pop_front();
          coef_checked++;
          if (want.row_number !== out_data.row_number ||
              want.component_number !== out_data.component_number ||
              want.coefficient !== out_data.coefficient ||
              want.last_of_row !== out_data.last_of_row) begin
            fail_count++;
            $display("%0t: expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b", $time,
                     want.row_number, want.component_number, want.coefficient,
                     want.last_of_row, out_data.row_number, out_data.component_number,
                     out_data.coefficient, out_data.last_of_row);
          end
        end
      end
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (in_valid && in_ready) project_input(in_data);
    end
    coef_pending = coef_expected_q.size();
  end

endmodule

>>> tb/two_d_pca_row_projection_tb.sv
// ----------------------------------------------------------------------------
// two_d_pca_row_projection_tb
// Stimulus and verdict for the 2dpca row projection block. The basis and mean
// entries that pixels read are filled first, then a directed part covers
// extreme samples, ignored loads, the unused action, clamped register values
// and a register change in the middle of a row, followed by random phases
// under several small image sizes. Both sides insert random gaps; the checker
// beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module two_d_pca_row_projection_tb;
  import tdpca_pkg::*;

  localparam logic [1:0] ACT_UNUSED   = 2'd3;
  localparam int         DRAIN_CYCLES = MAX_COMPONENTS + 8;
  localparam int         QUIET_LIMIT  = 2000;
  localparam int         IMG_COLS     = 2;
  localparam int         IMG_ROWS     = 4;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [6:0] cfg_data;

  int fail_count;
  int coef_pending;
  int coef_checked;
  int items_sent;
  int cfg_writes;
  int quiet_cycles;
  int out_stall;
  bit no_gaps;

  two_d_pca_row_projection u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  two_d_pca_row_projection_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .coef_pending (coef_pending),
    .coef_checked (coef_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver may stall after each transfer, except in gap-free phases
  initial begin
    out_ready = 1'b0;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (out_stall > 0) begin
        out_ready <= 1'b0;
        out_stall--;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
      if (out_valid && out_ready && !no_gaps) out_stall = $urandom_range(0, 4);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("two_d_pca_row_projection: mismatch");
      $finish;
    end
  end

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 11))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      3:       return 16'shffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t make_item(logic [1:0] act, int a, int b, int v);
    in_item_t it;
    it.action       = act;
    it.first_index  = 6'(a);
    it.second_index = 6'(b);
    it.sample_value = 16'(v);
    return it;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int       sel;
    sel             = $urandom_range(0, 99);
    it.first_index  = 6'($urandom);
    it.second_index = 6'($urandom);
    it.sample_value = rand_sample();
    if (sel < 75)      it.action = ACT_PIXEL;
    else if (sel < 85) it.action = ACT_BASIS;
    else if (sel < 95) it.action = ACT_MEAN;
    else               it.action = ACT_UNUSED;
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (coef_pending != 0);
  endtask

  task automatic wait_idle();
    wait_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    cfg_writes++;
  endtask

  task automatic write_config(int n, int c, int r);
    write_reg(CFG_N_COMPONENTS, 7'(n));
    write_reg(CFG_COLS_IN_USE, 7'(c));
    write_reg(CFG_ROWS_IN_USE, 7'(r));
  endtask

  task automatic run_phase(int n, int c, int r, int count, bit fast);
    wait_idle();
    write_config(n, c, r);
    no_gaps = fast;
    repeat (count) begin
      send_item(rand_item());
      if ($urandom_range(0, 29) == 0) wait_drain();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    no_gaps   = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fill the entries of the small image before any pixel reads them
    for (int j = 0; j < IMG_COLS; j++)
      for (int k = 0; k < MAX_COMPONENTS; k++)
        send_item(make_item(ACT_BASIS, j, k, int'(rand_sample())));
    for (int i = 0; i < IMG_ROWS; i++)
      for (int j = 0; j < IMG_COLS; j++)
        send_item(make_item(ACT_MEAN, i, j, int'(rand_sample())));

    // one pixel per row, extreme differences, clamped registers
    wait_idle();
    write_config(63, 0, 2);
    send_item(make_item(ACT_BASIS, 0, 0, -32768));
    send_item(make_item(ACT_BASIS, 0, 1, 32767));
    send_item(make_item(ACT_BASIS, 0, 40, 1234));
    send_item(make_item(ACT_UNUSED, 63, 63, -1));
    send_item(make_item(ACT_MEAN, 0, 0, 32767));
    send_item(make_item(ACT_MEAN, 1, 0, -32768));
    send_item(make_item(ACT_PIXEL, 0, 0, -32768));
    send_item(make_item(ACT_PIXEL, 63, 63, 32767));
    send_item(make_item(ACT_PIXEL, 0, 0, 0));

    // shrink the row and raise the component count in the middle of a row
    wait_idle();
    write_config(0, 2, 3);
    send_item(make_item(ACT_PIXEL, 0, 0, int'(rand_sample())));
    wait_idle();
    write_reg(CFG_COLS_IN_USE, 7'd1);
    write_reg(CFG_N_COMPONENTS, 7'd32);
    repeat (3) send_item(make_item(ACT_PIXEL, 0, 0, int'(rand_sample())));

    run_phase(32, 2, 4, 20, 1'b0);
    run_phase(1, 2, 1, 10, 1'b1);
    run_phase(64, 1, 0, 6, 1'b0);
    for (int p = 0; p < 2; p++)
      run_phase($urandom_range(1, 32), $urandom_range(1, IMG_COLS),
                $urandom_range(1, IMG_ROWS), 5, p == 1);

    wait_idle();
    $display("run: %0d input transfers and %0d register writes, images up to 2 by 4",
             items_sent, cfg_writes);
    $display("run: %0d coefficients compared, up to 32 per row, with a mid-row resize",
             coef_checked);
    if (fail_count == 0)
      $display("two_d_pca_row_projection: match");
    else
      $display("two_d_pca_row_projection: mismatch");
    $finish;
  end

endmodule
